@@ hw/rtl/mwd_pkg.sv @@
// Package for the multiword by word divider.
// Holds port widths, the word width default, the control struct and the FSM states.
// No dependencies.
package mwd_pkg;

  // Width of the data ports and of the divisor write port.
  localparam int unsigned PORT_BITS = 32;

  // Default width of one dividend word inside the datapath.
  localparam int unsigned WORD_BITS_DEF = 32;

  // Commands from the sequencer to the serial divide unit.
  typedef struct packed {
    logic start;  // load a new dividend word and begin the bit loop
    logic clear;  // drop the running remainder
  } mwd_ctrl_t;

  // Top level sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } mwd_state_e;

endpackage

@@ hw/rtl/multiword_by_word_divider.sv @@
// Top level of the multiword by word divider: sequencer, divisor register, result register.
// Instantiates mwd_serial_div; depends on mwd_pkg.
//
//   channel   direction  handshake                payload
//   in        to block   in_valid_i / in_stall_o  dividend_word_i, last_word_i
//   out       from block out_valid_o / out_stall_i quotient_word_o, remainder_word_o, is_last_o
//   cfg       to block   cfg_we_i                 cfg_wdata_i (divisor)
//
// A request is loaded, then the serial divide unit does one restoring
// subtract per quotient bit, its remainder feeding the next word, and the
// result is moved into the result register once that register is free.
// The result register lets the next request load while a result is stalled;
// a finished word waits in the unit only while the result register is full
// and stalled. Reset sets the divisor to 1 and clears the remainder. A zero
// divisor write is ignored; any other clears the running remainder.
module multiword_by_word_divider #(
  parameter int unsigned WORD_BITS = mwd_pkg::WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mwd_pkg::PORT_BITS-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mwd_pkg::PORT_BITS-1:0] dividend_word_i,
  input  logic                          last_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mwd_pkg::PORT_BITS-1:0] quotient_word_o,
  output logic [mwd_pkg::PORT_BITS-1:0] remainder_word_o,
  output logic                          is_last_o
);
  import mwd_pkg::*;

  mwd_state_e           state_q, state_d;
  mwd_ctrl_t            ctrl;
  logic [WORD_BITS-1:0] divisor_q, divisor_d;
  logic [WORD_BITS-1:0] cfg_word;
  logic                 cfg_take;
  logic                 last_q, last_d;
  logic                 in_take;
  logic                 out_free;
  logic                 out_load;
  logic                 out_valid_q, out_valid_d;
  logic [WORD_BITS-1:0] quo_out_q;
  logic [WORD_BITS-1:0] rem_out_q;
  logic                 last_out_q;
  logic                 div_busy;
  logic [WORD_BITS-1:0] div_quo;
  logic [WORD_BITS-1:0] div_rem;

  // Decode the divisor write; drop writes of zero
  assign cfg_word  = cfg_wdata_i[WORD_BITS-1:0];
  assign cfg_take  = cfg_we_i && (cfg_word != '0);
  assign divisor_d = cfg_take ? cfg_word : divisor_q;

  // Handshake qualifiers
  assign in_take  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!div_busy && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_RUN:  out_load   = !div_busy && out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

  // Commands to the divide unit; clear the remainder after the last word or on a divisor write
  always_comb begin
    ctrl.start = in_take;
    ctrl.clear = cfg_take || (out_load && last_q);
  end

  assign last_d      = in_take ? last_word_i : last_q;
  assign out_valid_d = out_load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      divisor_q   <= WORD_BITS'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      divisor_q   <= divisor_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: request flag and result
  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    if (out_load) begin
      quo_out_q  <= div_quo;
      rem_out_q  <= div_rem;
      last_out_q <= last_q;
    end
  end

  mwd_serial_div #(
    .WORD_BITS (WORD_BITS)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .word_i      (dividend_word_i[WORD_BITS-1:0]),
    .divisor_i   (divisor_q),
    .busy_o      (div_busy),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign out_valid_o      = out_valid_q;
  assign quotient_word_o  = PORT_BITS'(quo_out_q);
  assign remainder_word_o = PORT_BITS'(rem_out_q);
  assign is_last_o        = last_out_q;

  // The divisor register never holds zero
  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    divisor_q != '0)
    else $error("divisor register holds zero");

  // A request is taken only when the divide unit is free
  a_take_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |-> !div_busy)
    else $error("request taken while divide unit busy");

  // After a request is taken the unit is working on it
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (div_busy && in_stall_o))
    else $error("divide unit idle after request taken");

  // A result is loaded only from a finished unit into a free result register
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!div_busy && out_free && state_q == ST_RUN))
    else $error("result loaded before divide finished");

endmodule

@@ hw/rtl/mwd_serial_div.sv @@
// Bit-serial restoring divide unit: one quotient bit per cycle.
// Keeps the running remainder between words of one dividend.
// Depends on mwd_pkg.
module mwd_serial_div #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mwd_pkg::mwd_ctrl_t   ctrl_i,
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [WORD_BITS-1:0] divisor_i,
  output logic                 busy_o,
  output logic [WORD_BITS-1:0] quotient_o,
  output logic [WORD_BITS-1:0] remainder_o
);
  import mwd_pkg::*;

  localparam int unsigned CntW = $clog2(WORD_BITS + 1);

  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [WORD_BITS-1:0] rem_q, rem_d;
  logic [WORD_BITS-1:0] quo_q, quo_d;
  logic [WORD_BITS:0]   rem_ext;
  logic [WORD_BITS:0]   div_ext;
  logic [WORD_BITS:0]   diff;
  logic                 fits;

  // Shift the next dividend bit into the partial remainder and try a subtract
  always_comb begin
    rem_ext = {rem_q, quo_q[WORD_BITS-1]};
    div_ext = {1'b0, divisor_i};
    fits    = (rem_ext >= div_ext);
    diff    = rem_ext - div_ext;
  end

  // Next state of counter, remainder and dividend/quotient shift register
  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    if (ctrl_i.start) begin
      cnt_d = CntW'(WORD_BITS);
      quo_d = word_i;
    end else if (busy_o) begin
      cnt_d = cnt_q - CntW'(1);
      rem_d = fits ? diff[WORD_BITS-1:0] : rem_ext[WORD_BITS-1:0];
      quo_d = {quo_q[WORD_BITS-2:0], fits};
    end
    if (ctrl_i.clear) begin
      rem_d = '0;
    end
  end

  // Hold counter and running remainder under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rem_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      rem_q <= rem_d;
    end
  end

  // Quotient shift register carries payload only
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
  end

  assign busy_o      = (cnt_q != '0);
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule
